### src/hc26_pkg.sv
// Shared types, constants and mod-26 helpers for the Hill cipher block.
`default_nettype none

package hc26_pkg;

  localparam int unsigned MAX_BLOCK  = 3;
  localparam int unsigned MODULUS    = 26;
  localparam int unsigned PAD_LETTER = 23;
  localparam int unsigned KEY_CELLS  = MAX_BLOCK * MAX_BLOCK;
  localparam int unsigned ADJ_BIAS   = 650;

  typedef logic [4:0] letter_t;

  typedef enum logic [2:0] {
    CFG_BLOCK_SIZE = 3'd0,
    CFG_DECRYPT    = 3'd1,
    CFG_KEY_A      = 3'd2,
    CFG_KEY_B      = 3'd3,
    CFG_KEY_C      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_ADJ,
    S_DET,
    S_INV,
    S_RUN
  } back_state_e;

  typedef struct packed {
    logic        size3;
    logic        decrypt;
    logic [14:0] key_a;
    logic [14:0] key_b;
    logic [14:0] key_c;
  } cfg_t;

  typedef struct packed {
    logic                          size3;
    logic [MAX_BLOCK-1:0][4:0]     letters;
  } blk_t;

  function automatic letter_t mod26(input logic [10:0] v);
    logic [19:0] prod;
    logic [6:0]  q;
    logic [10:0] r;
    prod = 20'(v) * 20'(315);
    q    = prod[19:13];
    r    = v - (11'(q) * 11'(MODULUS));
    if (r >= 11'(MODULUS)) begin
      r = r - 11'(MODULUS);
    end
    return r[4:0];
  endfunction

  function automatic letter_t inv26(input letter_t d);
    letter_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/hc26_front.sv
// Front end: takes letters, fills the block buffer and hands on complete blocks.
`default_nettype none

module hc26_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [4:0]     in_letter_i,
  input  wire logic           message_end_i,
  input  wire logic           size3_i,
  input  wire logic           full_i,
  output logic                push_o,
  output hc26_pkg::blk_t      push_data_o
);

  logic [1:0]        fill_q, fill_d;
  hc26_pkg::letter_t buf_q [hc26_pkg::MAX_BLOCK];
  hc26_pkg::letter_t letter_mod;
  logic [1:0]        last_pos;
  logic [1:0]        pos;
  logic              done;
  logic              accept;

  always_comb begin
    letter_mod = (in_letter_i >= 5'(hc26_pkg::MODULUS)) ?
                 in_letter_i - 5'(hc26_pkg::MODULUS) : in_letter_i;
    last_pos   = size3_i ? 2'd2 : 2'd1;
    pos        = (fill_q > last_pos) ? last_pos : fill_q;
    done       = (pos == last_pos) || message_end_i;
    accept     = in_valid_i && !full_i;
    push_data_o.size3 = size3_i;
    for (int i = 0; i < hc26_pkg::MAX_BLOCK; i++) begin
      if (2'(i) < pos) begin
        push_data_o.letters[i] = buf_q[i];
      end else if (2'(i) == pos) begin
        push_data_o.letters[i] = letter_mod;
      end else begin
        push_data_o.letters[i] = 5'(hc26_pkg::PAD_LETTER);
      end
    end
    fill_d = fill_q;
    if (accept) begin
      fill_d = done ? 2'd0 : pos + 2'd1;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = accept && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      buf_q[pos] <= letter_mod;
    end
  end

endmodule

`default_nettype wire

### src/hc26_fifo.sv
// Two-entry block queue between front end and back end.
`default_nettype none

module hc26_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire hc26_pkg::blk_t push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output hc26_pkg::blk_t      data_o
);

  hc26_pkg::blk_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;

  always_comb begin
    full_o   = (count_q == 2'd2);
    valid_o  = (count_q != 2'd0);
    data_o   = mem_q[rd_ptr_q];
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("block pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("block popped from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

### src/hc26_back.sv
// Back end: prepares the working key and multiplies queued blocks into result letters.
`default_nettype none

module hc26_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire hc26_pkg::cfg_t cfg_i,
  input  wire logic           cfg_we_i,
  input  wire logic           blk_valid_i,
  input  wire hc26_pkg::blk_t blk_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [4:0]          out_letter_o,
  output logic                block_end_o,
  output logic                key_error_o
);

  hc26_pkg::back_state_e state_q, state_d;
  logic [3:0]            idx_q, idx_d;
  logic [1:0]            row_q, row_d;
  hc26_pkg::letter_t     adj_q  [hc26_pkg::KEY_CELLS];
  hc26_pkg::letter_t     keff_q [hc26_pkg::KEY_CELLS];
  hc26_pkg::letter_t     inv_q;
  logic                  err_q;
  logic                  out_valid_q;
  hc26_pkg::letter_t     out_letter_q;
  logic                  block_end_q;
  logic                  key_error_q;

  logic [2:0][14:0]      rows;
  hc26_pkg::letter_t     kmat [hc26_pkg::KEY_CELLS];
  hc26_pkg::letter_t     op_a, op_b, op_c, op_d;
  logic [10:0]           adj_sum;
  hc26_pkg::letter_t     det;
  hc26_pkg::letter_t     det_inv;
  hc26_pkg::letter_t     r0, r1, r2;
  hc26_pkg::letter_t     row_letter;
  logic                  last_row;
  logic                  out_free;
  logic                  emit;
  logic                  adj_we, det_we, keff_we;

  assign rows = {cfg_i.key_c, cfg_i.key_b, cfg_i.key_a};

  always_comb begin
    logic [4:0] raw;
    raw = 5'd0;
    for (int i = 0; i < hc26_pkg::MAX_BLOCK; i++) begin
      for (int j = 0; j < hc26_pkg::MAX_BLOCK; j++) begin
        raw = rows[i][5*j +: 5];
        if (!cfg_i.size3 && (i == 2 || j == 2)) begin
          kmat[3*i+j] = (i == j) ? 5'd1 : 5'd0;
        end else begin
          kmat[3*i+j] = (raw >= 5'(hc26_pkg::MODULUS)) ?
                        raw - 5'(hc26_pkg::MODULUS) : raw;
        end
      end
    end
  end

  always_comb begin
    unique case (idx_q)
      4'd0:    begin op_a = kmat[4]; op_b = kmat[8]; op_c = kmat[5]; op_d = kmat[7]; end
      4'd1:    begin op_a = kmat[2]; op_b = kmat[7]; op_c = kmat[1]; op_d = kmat[8]; end
      4'd2:    begin op_a = kmat[1]; op_b = kmat[5]; op_c = kmat[2]; op_d = kmat[4]; end
      4'd3:    begin op_a = kmat[5]; op_b = kmat[6]; op_c = kmat[3]; op_d = kmat[8]; end
      4'd4:    begin op_a = kmat[0]; op_b = kmat[8]; op_c = kmat[2]; op_d = kmat[6]; end
      4'd5:    begin op_a = kmat[2]; op_b = kmat[3]; op_c = kmat[0]; op_d = kmat[5]; end
      4'd6:    begin op_a = kmat[3]; op_b = kmat[7]; op_c = kmat[4]; op_d = kmat[6]; end
      4'd7:    begin op_a = kmat[1]; op_b = kmat[6]; op_c = kmat[0]; op_d = kmat[7]; end
      4'd8:    begin op_a = kmat[0]; op_b = kmat[4]; op_c = kmat[1]; op_d = kmat[3]; end
      default: begin op_a = 5'd0;    op_b = 5'd0;    op_c = 5'd0;    op_d = 5'd0;    end
    endcase
    adj_sum = 11'(hc26_pkg::ADJ_BIAS) + (11'(op_a) * 11'(op_b)) - (11'(op_c) * 11'(op_d));
    det     = hc26_pkg::mod26((11'(kmat[0]) * 11'(adj_q[0])) +
                              (11'(kmat[1]) * 11'(adj_q[3])) +
                              (11'(kmat[2]) * 11'(adj_q[6])));
    det_inv = hc26_pkg::inv26(det);
  end

  always_comb begin
    unique case (row_q)
      2'd0:    begin r0 = keff_q[0]; r1 = keff_q[1]; r2 = keff_q[2]; end
      2'd1:    begin r0 = keff_q[3]; r1 = keff_q[4]; r2 = keff_q[5]; end
      2'd2:    begin r0 = keff_q[6]; r1 = keff_q[7]; r2 = keff_q[8]; end
      default: begin r0 = 5'd0;      r1 = 5'd0;      r2 = 5'd0;      end
    endcase
    row_letter = hc26_pkg::mod26((11'(r0) * 11'(blk_i.letters[0])) +
                                 (11'(r1) * 11'(blk_i.letters[1])) +
                                 (11'(r2) * 11'(blk_i.letters[2])));
    last_row   = (row_q == (blk_i.size3 ? 2'd2 : 2'd1));
    out_free   = !out_valid_q || out_ready_i;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    row_d   = row_q;
    pop_o   = 1'b0;
    emit    = 1'b0;
    adj_we  = 1'b0;
    det_we  = 1'b0;
    keff_we = 1'b0;
    if (cfg_we_i) begin
      state_d = hc26_pkg::S_ADJ;
      idx_d   = 4'd0;
      row_d   = 2'd0;
    end else begin
      unique case (state_q)
        hc26_pkg::S_ADJ: begin
          adj_we = 1'b1;
          if (idx_q == 4'(hc26_pkg::KEY_CELLS - 1)) begin
            idx_d   = 4'd0;
            state_d = hc26_pkg::S_DET;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        hc26_pkg::S_DET: begin
          det_we  = 1'b1;
          state_d = hc26_pkg::S_INV;
        end
        hc26_pkg::S_INV: begin
          keff_we = 1'b1;
          if (idx_q == 4'(hc26_pkg::KEY_CELLS - 1)) begin
            idx_d   = 4'd0;
            state_d = hc26_pkg::S_RUN;
          end else begin
            idx_d = idx_q + 4'd1;
          end
        end
        hc26_pkg::S_RUN: begin
          if (blk_valid_i && out_free) begin
            emit = 1'b1;
            if (err_q || last_row) begin
              pop_o = 1'b1;
              row_d = 2'd0;
            end else begin
              row_d = row_q + 2'd1;
            end
          end
        end
        default: state_d = hc26_pkg::S_ADJ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hc26_pkg::S_ADJ;
      idx_q       <= 4'd0;
      row_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      row_q   <= row_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_q[idx_q] <= hc26_pkg::mod26(adj_sum);
    end
    if (det_we) begin
      inv_q <= det_inv;
      err_q <= cfg_i.decrypt && (det_inv == 5'd0);
    end
    if (keff_we) begin
      keff_q[idx_q] <= cfg_i.decrypt ?
                       hc26_pkg::mod26(11'(adj_q[idx_q]) * 11'(inv_q)) : kmat[idx_q];
    end
    if (emit) begin
      out_letter_q <= err_q ? 5'd0 : row_letter;
      block_end_q  <= err_q || last_row;
      key_error_q  <= err_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_letter_o = out_letter_q;
  assign block_end_o  = block_end_q;
  assign key_error_o  = key_error_q;

`ifndef SYNTHESIS
  a_err_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_error_o) |-> (block_end_o && out_letter_o == 5'd0))
    else $error("key error result malformed");
  a_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == hc26_pkg::S_RUN && emit))
    else $error("block dropped without a result");
  a_cfg_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (state_q == hc26_pkg::S_ADJ && idx_q == 4'd0))
    else $error("key preparation not restarted after register write");
`endif

endmodule

`default_nettype wire

### src/hill_cipher_mod26_top.sv
// Top level of the mod-26 Hill cipher: register file and front/queue/back wiring.
//
// Channels: letters enter on in_valid_i/in_ready_o with in_letter_i and
// message_end_i; results leave on out_valid_o/out_ready_i as out_letter_o,
// block_end_o and key_error_o. Registers are written on cfg_valid_i with
// cfg_index_i and cfg_data_i; cfg_ready_o is always high.
// A block of 2 or 3 letters (or a shorter one closed by message_end_i and
// padded with x) yields one result per key row, block_end_o on the last;
// in decrypt mode a key with no inverse yields one result with key_error_o.
// The first result of a block goes through the queue and the output register
// after its final letter is accepted. Throughput: one letter per cycle while
// the queue is not full; the back end issues one result per cycle while the
// receiver is ready, from its single row multiply-reduce unit.
// After reset and after every register write the back end builds the working
// key (9 adjugate cells, determinant, 9 scaled cells); letters are still taken
// meanwhile and complete blocks wait in a two-block queue. When the receiver
// stalls the result is held in the output register, the queue fills and
// in_ready_o drops once it holds two blocks.
// Reset clears the block fill count, the queue and the output register, and
// sets block size 2, encrypt mode and an all-zero key.
`default_nettype none

module hill_cipher_mod26_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [4:0]  in_letter_i,
  input  wire logic        message_end_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       out_letter_o,
  output logic             block_end_o,
  output logic             key_error_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [14:0] cfg_data_i
);

  hc26_pkg::cfg_t cfg_q, cfg_d;
  logic           cfg_we;
  logic           push;
  hc26_pkg::blk_t push_data;
  logic           full;
  logic           pop;
  logic           blk_valid;
  hc26_pkg::blk_t blk;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we) begin
      unique case (cfg_index_i)
        hc26_pkg::CFG_BLOCK_SIZE: cfg_d.size3   = (cfg_data_i[1:0] == 2'b11);
        hc26_pkg::CFG_DECRYPT:    cfg_d.decrypt = cfg_data_i[0];
        hc26_pkg::CFG_KEY_A:      cfg_d.key_a   = cfg_data_i;
        hc26_pkg::CFG_KEY_B:      cfg_d.key_b   = cfg_data_i;
        hc26_pkg::CFG_KEY_C:      cfg_d.key_c   = cfg_data_i;
        default:                  cfg_d         = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  hc26_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_letter_i   (in_letter_i),
    .message_end_i (message_end_i),
    .size3_i       (cfg_q.size3),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  hc26_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (blk_valid),
    .data_o      (blk)
  );

  hc26_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cfg_we_i     (cfg_we),
    .blk_valid_i  (blk_valid),
    .blk_i        (blk),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_letter_o (out_letter_o),
    .block_end_o  (block_end_o),
    .key_error_o  (key_error_o)
  );

endmodule

`default_nettype wire

### tb/tb_hill_cipher_mod26_top.sv
// Self-checking testbench for hill_cipher_mod26_top: directed and random letter streams.
`timescale 1ns / 100ps

module tb_hill_cipher_mod26_top;

  localparam int DRAIN_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;

  typedef logic [2:0][2:0][4:0] key_mat_t;

  typedef struct packed {
    hc26_pkg::letter_t letter;
    logic              blk_end;
    logic              kerr;
  } cipher_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [4:0]  in_letter_i;
  logic        message_end_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [4:0]  out_letter_o;
  logic        block_end_o;
  logic        key_error_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [14:0] cfg_data_i;

  cipher_res_t       ciphertext_q [$];
  int                err_count    = 0;
  int                idle_cycles  = 0;
  int                tx_idle_pct  = 0;
  int                rx_stall_pct = 0;
  int                rx_hold_left = 0;

  logic [1:0]        cfg_size     = 2'd2;
  logic              cfg_decrypt  = 1'b0;
  logic [14:0]       cfg_row_a    = '0;
  logic [14:0]       cfg_row_b    = '0;
  logic [14:0]       cfg_row_c    = '0;
  logic [2:0][4:0]   letter_buf   = '0;
  int                fill_cnt     = 0;

  hill_cipher_mod26_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_letter_i   (in_letter_i),
    .message_end_i (message_end_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_letter_o  (out_letter_o),
    .block_end_o   (block_end_o),
    .key_error_o   (key_error_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int wrap26(input int v);
    int r;
    r = v % int'(hc26_pkg::MODULUS);
    return (r < 0) ? r + int'(hc26_pkg::MODULUS) : r;
  endfunction

  function automatic key_mat_t unpack_key(input logic [14:0] ra, input logic [14:0] rb,
                                          input logic [14:0] rc);
    key_mat_t m;
    for (int j = 0; j < 3; j++) begin
      m[0][j] = 5'(ra[5*j +: 5] % hc26_pkg::MODULUS);
      m[1][j] = 5'(rb[5*j +: 5] % hc26_pkg::MODULUS);
      m[2][j] = 5'(rc[5*j +: 5] % hc26_pkg::MODULUS);
    end
    return m;
  endfunction

  function automatic bit invert_key(input key_mat_t k, input bit size3,
                                    output key_mat_t inv_k);
    int e [3][3];
    int a [3][3];
    int det;
    int inv;
    int n;
    inv_k = '0;
    n = size3 ? 3 : 2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        e[i][j] = int'(k[i][j]);
        a[i][j] = 0;
      end
    end
    if (!size3) begin
      det = wrap26(e[0][0] * e[1][1] - e[0][1] * e[1][0]);
      a[0][0] = e[1][1];
      a[0][1] = -e[0][1];
      a[1][0] = -e[1][0];
      a[1][1] = e[0][0];
    end else begin
      a[0][0] = e[1][1] * e[2][2] - e[1][2] * e[2][1];
      a[0][1] = e[0][2] * e[2][1] - e[0][1] * e[2][2];
      a[0][2] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      a[1][0] = e[1][2] * e[2][0] - e[1][0] * e[2][2];
      a[1][1] = e[0][0] * e[2][2] - e[0][2] * e[2][0];
      a[1][2] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      a[2][0] = e[1][0] * e[2][1] - e[1][1] * e[2][0];
      a[2][1] = e[0][1] * e[2][0] - e[0][0] * e[2][1];
      a[2][2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      det = wrap26(e[0][0] * a[0][0] + e[0][1] * a[1][0] + e[0][2] * a[2][0]);
    end
    inv = 0;
    for (int x = 1; x < 26; x++) begin
      if ((det * x) % 26 == 1) begin
        inv = x;
      end
    end
    if (inv == 0) begin
      return 1'b0;
    end
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        inv_k[i][j] = 5'(wrap26(wrap26(a[i][j]) * inv));
      end
    end
    return 1'b1;
  endfunction

  task automatic hill_step(input hc26_pkg::letter_t letter, input bit mend);
    int          n;
    int          pos;
    int          acc;
    key_mat_t    k;
    key_mat_t    ki;
    cipher_res_t r;
    n   = (cfg_size == 2'd3) ? 3 : 2;
    pos = fill_cnt;
    if (pos >= n) begin
      pos = n - 1;
    end
    letter_buf[pos] = 5'(letter % hc26_pkg::MODULUS);
    pos++;
    fill_cnt = pos;
    if (pos < n && !mend) begin
      return;
    end
    for (int i = pos; i < n; i++) begin
      letter_buf[i] = 5'(hc26_pkg::PAD_LETTER);
    end
    fill_cnt = 0;
    k = unpack_key(cfg_row_a, cfg_row_b, cfg_row_c);
    if (cfg_decrypt) begin
      if (!invert_key(k, n == 3, ki)) begin
        r.letter  = '0;
        r.blk_end = 1'b1;
        r.kerr    = 1'b1;
        ciphertext_q.push_back(r);
        return;
      end
      k = ki;
    end
    for (int i = 0; i < n; i++) begin
      acc = 0;
      for (int j = 0; j < n; j++) begin
        acc = (acc + int'(k[i][j]) * int'(letter_buf[j])) % 26;
      end
      r.letter  = 5'(acc);
      r.blk_end = (i == n - 1);
      r.kerr    = 1'b0;
      ciphertext_q.push_back(r);
    end
  endtask

  function automatic hc26_pkg::letter_t rand_letter();
    return ($urandom_range(7) == 0) ? 5'($urandom_range(31, 26))
                                    : 5'($urandom_range(25));
  endfunction

  function automatic logic [14:0] rand_row();
    if ($urandom_range(7) == 0) begin
      return 15'($urandom_range(32767));
    end
    return {5'($urandom_range(25)), 5'($urandom_range(25)), 5'($urandom_range(25))};
  endfunction

  task automatic send_letter(input hc26_pkg::letter_t letter, input bit mend);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    in_letter_i   = letter;
    message_end_i = mend;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    hill_step(letter, mend);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (ciphertext_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input hc26_pkg::cfg_idx_e idx, input logic [14:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(posedge clk_i);
    while (!cfg_ready_o) begin
      @(posedge clk_i);
    end
    case (idx)
      hc26_pkg::CFG_BLOCK_SIZE: cfg_size    = data[1:0];
      hc26_pkg::CFG_DECRYPT:    cfg_decrypt = data[0];
      hc26_pkg::CFG_KEY_A:      cfg_row_a   = data;
      hc26_pkg::CFG_KEY_B:      cfg_row_b   = data;
      hc26_pkg::CFG_KEY_C:      cfg_row_c   = data;
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [14:0] size_w, input logic [14:0] dec_w,
                              input logic [14:0] ka, input logic [14:0] kb,
                              input logic [14:0] kc);
    settle();
    write_reg(hc26_pkg::CFG_BLOCK_SIZE, size_w);
    write_reg(hc26_pkg::CFG_DECRYPT, dec_w);
    write_reg(hc26_pkg::CFG_KEY_A, ka);
    write_reg(hc26_pkg::CFG_KEY_B, kb);
    write_reg(hc26_pkg::CFG_KEY_C, kc);
    cfg_valid_i = 1'b0;
  endtask

  task automatic shuffle_config();
    logic [1:0]  sz;
    logic        dec;
    bit          want_inv;
    logic [14:0] ra;
    logic [14:0] rb;
    logic [14:0] rc;
    key_mat_t    scratch;
    sz       = 2'($urandom_range(3));
    dec      = 1'($urandom_range(1));
    want_inv = dec && ($urandom_range(3) != 0);
    do begin
      ra = rand_row();
      rb = rand_row();
      rc = rand_row();
    end while (want_inv && !invert_key(unpack_key(ra, rb, rc), sz == 2'd3, scratch));
    apply_config({13'($urandom), sz}, {14'($urandom), dec}, ra, rb, rc);
  endtask

  task automatic test_reset_defaults();
    send_letter(5'd5, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd7, 1'b1);
  endtask

  task automatic test_encrypt_extremes();
    apply_config(15'd2, 15'd0, {5'd0, 5'd3, 5'd3}, {5'd0, 5'd5, 5'd2}, 15'd0);
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b1);
    send_letter(5'd19, 1'b1);
    apply_config(15'h7FFF, 15'h7FFE, 15'h7FFF, 15'h7FFF, 15'h7FFF);
    send_letter(5'd25, 1'b1);
    send_letter(5'd1, 1'b0);
    send_letter(5'd2, 1'b1);
    send_letter(5'd3, 1'b0);
    send_letter(5'd4, 1'b0);
    send_letter(5'd5, 1'b0);
  endtask

  task automatic test_decrypt_keys();
    apply_config(15'd2, 15'd1, {5'd0, 5'd3, 5'd3}, {5'd0, 5'd5, 5'd2}, 15'd0);
    send_letter(5'd7, 1'b0);
    send_letter(5'd8, 1'b0);
    // singular 2x2 key: expect the error item
    apply_config(15'd2, 15'd1, {5'd0, 5'd4, 5'd2}, {5'd0, 5'd2, 5'd1}, 15'd0);
    send_letter(5'd1, 1'b1);
    apply_config(15'd3, 15'd1, {5'd1, 5'd24, 5'd6}, {5'd10, 5'd16, 5'd13},
                 {5'd15, 5'd17, 5'd20});
    send_letter(5'd0, 1'b0);
    send_letter(5'd2, 1'b0);
    send_letter(5'd19, 1'b0);
    apply_config(15'd3, 15'd1, 15'd0, 15'd0, 15'd0);
    send_letter(5'd4, 1'b1);
  endtask

  task automatic test_mid_block_changes();
    apply_config(15'd3, 15'd0, {5'd7, 5'd2, 5'd9}, {5'd1, 5'd25, 5'd4},
                 {5'd11, 5'd0, 5'd13});
    send_letter(5'd10, 1'b0);
    send_letter(5'd11, 1'b0);
    // shrink the block with two letters held: the next item overwrites the last slot
    apply_config(15'd1, 15'd0, {5'd7, 5'd2, 5'd9}, {5'd1, 5'd25, 5'd4},
                 {5'd11, 5'd0, 5'd13});
    send_letter(5'd12, 1'b0);
    send_letter(5'd13, 1'b0);
    apply_config(15'd0, 15'd0, {5'd0, 5'd17, 5'd21}, {5'd1, 5'd25, 5'd4},
                 {5'd11, 5'd0, 5'd13});
    send_letter(5'd14, 1'b1);
  endtask

  task automatic test_output_backpressure();
    apply_config(15'd2, 15'd0, {5'd0, 5'd3, 5'd3}, {5'd0, 5'd5, 5'd2}, 15'd0);
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(posedge clk_i);
    rx_hold_left = HOLD_CYCLES;
    @(negedge clk_i);
    repeat (16) send_letter(rand_letter(), 1'b0);
    settle();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (4) begin
      shuffle_config();
      repeat (15) send_letter(rand_letter(), $urandom_range(9) == 0);
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        out_ready_i  = 1'b0;
        rx_hold_left = rx_hold_left - 1;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    cipher_res_t want;
    if (out_valid_o && out_ready_i) begin
      if (ciphertext_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual letter %0d end %0b err %0b",
                 $time, out_letter_o, block_end_o, key_error_o);
        err_count++;
      end else begin
        want = ciphertext_q.pop_front();
        if (out_letter_o !== want.letter) begin
          $display("%0t: out_letter expected %0d actual %0d", $time, want.letter,
                   out_letter_o);
          err_count++;
        end
        if (block_end_o !== want.blk_end) begin
          $display("%0t: block_end expected %0b actual %0b", $time, want.blk_end,
                   block_end_o);
          err_count++;
        end
        if (key_error_o !== want.kerr) begin
          $display("%0t: key_error expected %0b actual %0b", $time, want.kerr,
                   key_error_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired with %0d items outstanding", $time,
                 ciphertext_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_letter_i   = '0;
    message_end_i = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = hc26_pkg::CFG_BLOCK_SIZE;
    cfg_data_i    = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_encrypt_extremes();
    test_decrypt_keys();
    test_mid_block_changes();
    test_output_backpressure();
    test_random_traffic(0, 0);
    test_random_traffic(58, 0);
    test_random_traffic(0, 58);
    test_random_traffic(14, 14);
    settle();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/hc26_pkg.sv
src/hc26_front.sv
src/hc26_fifo.sv
src/hc26_back.sv
src/hill_cipher_mod26_top.sv
tb/tb_hill_cipher_mod26_top.sv
